// ===== hdl/rhsv_pkg.sv =====
// Shared constants and types for the RGB to HSV converter.
package rhsv_pkg;

  // Default widths of a color channel and of a hue/saturation fraction
  localparam int unsigned ChannelBitsDef  = 8;
  localparam int unsigned FractionBitsDef = 16;

  // Per-pixel flags carried along the divider chain
  typedef struct packed {
    logic grey;  // all channels equal: hue and saturation forced to zero
    logic full;  // smallest channel zero, not grey: saturation saturates
  } rhsv_flags_t;

endpackage

// ===== hdl/rhsv_prep.sv =====
// Front stage: max/min search, spread, hue numerator and divisors, registered.
module rhsv_prep #(
  parameter int unsigned CHANNEL_BITS = 8
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      valid_i,
  output logic                      ready_o,
  input  logic [CHANNEL_BITS-1:0]   red_i,
  input  logic [CHANNEL_BITS-1:0]   green_i,
  input  logic [CHANNEL_BITS-1:0]   blue_i,
  output logic                      valid_o,
  input  logic                      ready_i,
  output rhsv_pkg::rhsv_flags_t     flags_o,
  output logic [CHANNEL_BITS-1:0]   bright_o,
  output logic [CHANNEL_BITS-1:0]   srem_o,
  output logic [CHANNEL_BITS-1:0]   sdiv_o,
  output logic [CHANNEL_BITS+2:0]   hrem_o,
  output logic [CHANNEL_BITS+2:0]   hdiv_o
);
  import rhsv_pkg::*;

  localparam int unsigned CW = CHANNEL_BITS;
  localparam int unsigned HW = CHANNEL_BITS + 3;

  logic [CW-1:0]        hi, lo, spread;
  logic [HW-1:0]        six_d;
  logic signed [HW:0]   num, num_wrap;
  logic signed [HW:0]   r_s, g_s, b_s, d_s;
  rhsv_flags_t          flags_d;

  logic                 valid_q;
  rhsv_flags_t          flags_q;
  logic [CW-1:0]        bright_q, srem_q, sdiv_q;
  logic [HW-1:0]        hrem_q, hdiv_q;

  // Largest and smallest channel, spread and hue numerator
  always_comb begin
    hi = red_i;
    lo = red_i;
    if (green_i > hi) hi = green_i;
    if (blue_i > hi) hi = blue_i;
    if (green_i < lo) lo = green_i;
    if (blue_i < lo) lo = blue_i;
    spread = hi - lo;
    six_d  = {1'b0, spread, 2'b00} + {2'b00, spread, 1'b0};

    r_s = $signed({4'b0000, red_i});
    g_s = $signed({4'b0000, green_i});
    b_s = $signed({4'b0000, blue_i});
    d_s = $signed({4'b0000, spread});

    // Sector chosen by largest channel: red, then green, then blue
    if (red_i == hi) begin
      num = g_s - b_s;
    end else if (green_i == hi) begin
      num = (d_s <<< 1) + b_s - r_s;
    end else begin
      num = (d_s <<< 2) + r_s - g_s;
    end
    // Wrap negative numerators into one turn
    num_wrap = num[HW] ? num + $signed({1'b0, six_d}) : num;

    flags_d.grey = (spread == '0);
    flags_d.full = (lo == '0) && (spread != '0);
  end

  assign ready_o = !valid_q || ready_i;

  // Stage register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready_o && valid_i) begin
      flags_q  <= flags_d;
      bright_q <= hi;
      srem_q   <= spread;
      sdiv_q   <= hi;
      hrem_q   <= num_wrap[HW-1:0];
      hdiv_q   <= six_d;
    end
  end

  assign valid_o  = valid_q;
  assign flags_o  = flags_q;
  assign bright_o = bright_q;
  assign srem_o   = srem_q;
  assign sdiv_o   = sdiv_q;
  assign hrem_o   = hrem_q;
  assign hdiv_o   = hdiv_q;

endmodule

// ===== hdl/rhsv_div_cell.sv =====
// One restoring-division cell: resolves one quotient bit of saturation and hue.
module rhsv_div_cell #(
  parameter int unsigned CHANNEL_BITS  = 8,
  parameter int unsigned FRACTION_BITS = 16,
  parameter int unsigned STEP          = 0
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       valid_i,
  output logic                       ready_o,
  input  rhsv_pkg::rhsv_flags_t      flags_i,
  input  logic [CHANNEL_BITS-1:0]    bright_i,
  input  logic [CHANNEL_BITS-1:0]    srem_i,
  input  logic [CHANNEL_BITS-1:0]    sdiv_i,
  input  logic [CHANNEL_BITS+2:0]    hrem_i,
  input  logic [CHANNEL_BITS+2:0]    hdiv_i,
  input  logic [FRACTION_BITS-1:0]   squo_i,
  input  logic [FRACTION_BITS-1:0]   hquo_i,
  output logic                       valid_o,
  input  logic                       ready_i,
  output rhsv_pkg::rhsv_flags_t      flags_o,
  output logic [CHANNEL_BITS-1:0]    bright_o,
  output logic [CHANNEL_BITS-1:0]    srem_o,
  output logic [CHANNEL_BITS-1:0]    sdiv_o,
  output logic [CHANNEL_BITS+2:0]    hrem_o,
  output logic [CHANNEL_BITS+2:0]    hdiv_o,
  output logic [FRACTION_BITS-1:0]   squo_o,
  output logic [FRACTION_BITS-1:0]   hquo_o
);
  import rhsv_pkg::*;

  localparam int unsigned CW  = CHANNEL_BITS;
  localparam int unsigned HW  = CHANNEL_BITS + 3;
  localparam int unsigned BIT = FRACTION_BITS - 1 - STEP;

  logic [CW:0]               srem2, sdiff;
  logic [HW:0]               hrem2, hdiff;
  logic                      sge, hge;
  logic [CW-1:0]             srem_d;
  logic [HW-1:0]             hrem_d;
  logic [FRACTION_BITS-1:0]  squo_d, hquo_d;

  logic                      valid_q;
  rhsv_flags_t               flags_q;
  logic [CW-1:0]             bright_q, srem_q, sdiv_q;
  logic [HW-1:0]             hrem_q, hdiv_q;
  logic [FRACTION_BITS-1:0]  squo_q, hquo_q;

  // Shift remainder, trial subtract, keep or restore
  always_comb begin
    srem2  = {srem_i, 1'b0};
    sdiff  = srem2 - {1'b0, sdiv_i};
    sge    = (srem2 >= {1'b0, sdiv_i});
    srem_d = sge ? sdiff[CW-1:0] : srem2[CW-1:0];

    hrem2  = {hrem_i, 1'b0};
    hdiff  = hrem2 - {1'b0, hdiv_i};
    hge    = (hrem2 >= {1'b0, hdiv_i});
    hrem_d = hge ? hdiff[HW-1:0] : hrem2[HW-1:0];

    squo_d      = squo_i;
    squo_d[BIT] = sge;
    hquo_d      = hquo_i;
    hquo_d[BIT] = hge;
  end

  assign ready_o = !valid_q || ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready_o && valid_i) begin
      flags_q  <= flags_i;
      bright_q <= bright_i;
      srem_q   <= srem_d;
      sdiv_q   <= sdiv_i;
      hrem_q   <= hrem_d;
      hdiv_q   <= hdiv_i;
      squo_q   <= squo_d;
      hquo_q   <= hquo_d;
    end
  end

  assign valid_o  = valid_q;
  assign flags_o  = flags_q;
  assign bright_o = bright_q;
  assign srem_o   = srem_q;
  assign sdiv_o   = sdiv_q;
  assign hrem_o   = hrem_q;
  assign hdiv_o   = hdiv_q;
  assign squo_o   = squo_q;
  assign hquo_o   = hquo_q;

endmodule

// ===== hdl/rgb_to_hsv_converter.sv =====
// Top level of the pipelined RGB to HSV converter.
//
// Accepts one pixel per clock unless in_stall_o is raised and returns one HSV
// result per pixel, in order. A front stage finds the largest and smallest
// channel and forms the hue numerator and divisors; behind it sits a chain of
// FRACTION_BITS division cells, each resolving one quotient bit of saturation
// and of hue, so the throughput is one pixel per cycle while the output is not
// stalled, and each result passes through the front stage register and every
// cell register in turn. Every stage holds its transaction while its successor
// stalls, so bubbles collapse and input is stalled only when all stages are
// full and the output is stalled. Grey pixels give zero hue and saturation; a
// non-grey pixel with a zero channel saturates to all ones.
module rgb_to_hsv_converter #(
  parameter int unsigned CHANNEL_BITS  = rhsv_pkg::ChannelBitsDef,
  parameter int unsigned FRACTION_BITS = rhsv_pkg::FractionBitsDef
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       in_valid_i,
  output logic                       in_stall_o,
  input  logic [CHANNEL_BITS-1:0]    red_i,
  input  logic [CHANNEL_BITS-1:0]    green_i,
  input  logic [CHANNEL_BITS-1:0]    blue_i,
  output logic                       out_valid_o,
  input  logic                       out_stall_i,
  output logic [FRACTION_BITS-1:0]   hue_o,
  output logic [FRACTION_BITS-1:0]   saturation_o,
  output logic [CHANNEL_BITS-1:0]    brightness_o
);
  import rhsv_pkg::*;

  localparam int unsigned CW    = CHANNEL_BITS;
  localparam int unsigned HW    = CHANNEL_BITS + 3;
  localparam int unsigned FW    = FRACTION_BITS;
  localparam int unsigned DEPTH = FRACTION_BITS + 1;
  localparam int unsigned OCW   = $clog2(DEPTH + 1);

  logic               valid  [FW+1];
  logic               ready  [FW+1];
  rhsv_flags_t        flags  [FW+1];
  logic [CW-1:0]      bright [FW+1];
  logic [CW-1:0]      srem   [FW+1];
  logic [CW-1:0]      sdiv   [FW+1];
  logic [HW-1:0]      hrem   [FW+1];
  logic [HW-1:0]      hdiv   [FW+1];
  logic [FW-1:0]      squo   [FW+1];
  logic [FW-1:0]      hquo   [FW+1];
  logic               in_ready;

  // Front stage
  rhsv_prep #(
    .CHANNEL_BITS (CHANNEL_BITS)
  ) u_prep (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .valid_i  (in_valid_i),
    .ready_o  (in_ready),
    .red_i    (red_i),
    .green_i  (green_i),
    .blue_i   (blue_i),
    .valid_o  (valid[0]),
    .ready_i  (ready[0]),
    .flags_o  (flags[0]),
    .bright_o (bright[0]),
    .srem_o   (srem[0]),
    .sdiv_o   (sdiv[0]),
    .hrem_o   (hrem[0]),
    .hdiv_o   (hdiv[0])
  );

  assign squo[0] = '0;
  assign hquo[0] = '0;

  // Division chain, one quotient bit per cell
  for (genvar k = 0; k < FW; k++) begin : g_cell
    rhsv_div_cell #(
      .CHANNEL_BITS  (CHANNEL_BITS),
      .FRACTION_BITS (FRACTION_BITS),
      .STEP          (k)
    ) u_cell (
      .clk_i    (clk_i),
      .rst_ni   (rst_ni),
      .valid_i  (valid[k]),
      .ready_o  (ready[k]),
      .flags_i  (flags[k]),
      .bright_i (bright[k]),
      .srem_i   (srem[k]),
      .sdiv_i   (sdiv[k]),
      .hrem_i   (hrem[k]),
      .hdiv_i   (hdiv[k]),
      .squo_i   (squo[k]),
      .hquo_i   (hquo[k]),
      .valid_o  (valid[k+1]),
      .ready_i  (ready[k+1]),
      .flags_o  (flags[k+1]),
      .bright_o (bright[k+1]),
      .srem_o   (srem[k+1]),
      .sdiv_o   (sdiv[k+1]),
      .hrem_o   (hrem[k+1]),
      .hdiv_o   (hdiv[k+1]),
      .squo_o   (squo[k+1]),
      .hquo_o   (hquo[k+1])
    );
  end

  assign ready[FW] = !out_stall_i;
  assign in_stall_o = !in_ready;

  // Output selection: grey and saturated special cases
  assign out_valid_o  = valid[FW];
  assign brightness_o = bright[FW];
  assign hue_o        = flags[FW].grey ? '0 : hquo[FW];
  assign saturation_o = flags[FW].grey ? '0 :
                        flags[FW].full ? '1 : squo[FW];

  // Occupancy count for checks
  logic [OCW-1:0] occ_q, occ_d;
  logic           acc_in, acc_out;

  assign acc_in  = in_valid_i && !in_stall_o;
  assign acc_out = out_valid_o && !out_stall_i;

  always_comb begin
    occ_d = occ_q;
    if (acc_in && !acc_out) begin
      occ_d = occ_q + OCW'(1);
    end else if (acc_out && !acc_in) begin
      occ_d = occ_q - OCW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      occ_q <= '0;
    end else begin
      occ_q <= occ_d;
    end
  end

  // Input stalls only when the output is backed up
  a_stall_backpressure : assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> (out_valid_o && out_stall_i))
    else $error("input stalled without output backpressure");

  // Pipeline never holds more transactions than it has stages
  a_occ_bound : assert property (@(posedge clk_i) disable iff (!rst_ni)
    occ_q <= OCW'(DEPTH))
    else $error("occupancy exceeds pipeline depth");

  // No result appears from an empty pipeline
  a_no_phantom : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (occ_q == '0) |-> !out_valid_o)
    else $error("result delivered with no transaction in flight");

  // A full pipeline with a stalled output must stall the input
  a_full_stall : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (occ_q == OCW'(DEPTH)) && out_stall_i |-> in_stall_o)
    else $error("full pipeline accepted input");

endmodule

// ===== sim/tb.sv =====
// Self-checking testbench for the RGB to HSV converter: predictor, scoreboard, directed and random stimulus.
`timescale 1ns / 1ps

module tb;

  localparam int unsigned ChanBits = rhsv_pkg::ChannelBitsDef;
  localparam int unsigned FracBits = rhsv_pkg::FractionBitsDef;
  localparam int unsigned Latency  = FracBits + 1;

  typedef logic [ChanBits-1:0] chan_t;
  typedef logic [FracBits-1:0] frac_t;

  typedef struct packed {
    frac_t hue;
    frac_t saturation;
    chan_t brightness;
  } hsv_t;

  // Holds the predicted HSV of every accepted pixel, oldest first
  class hsv_scoreboard;
    hsv_t        expected_hsv_q[$];
    int unsigned fail_count;

    // Exact integer conversion of one pixel
    function hsv_t predict_hsv(chan_t r, chan_t g, chan_t b);
      longint rr, gg, bb, hi, lo, spread, num, frac_max;
      hsv_t   res;
      rr       = r;
      gg       = g;
      bb       = b;
      frac_max = (longint'(1) << FracBits) - 1;
      hi       = rr;
      lo       = rr;
      if (gg > hi) hi = gg;
      if (bb > hi) hi = bb;
      if (gg < lo) lo = gg;
      if (bb < lo) lo = bb;
      spread = hi - lo;
      res.hue        = '0;
      res.saturation = '0;
      res.brightness = chan_t'(hi);
      // Grey pixels keep zero hue and saturation
      if (spread != 0) begin
        num = (spread << FracBits) / hi;
        if (num > frac_max) num = frac_max;
        res.saturation = frac_t'(num);
        // Sector by largest channel: red wins ties, then green
        if (rr == hi) begin
          num = gg - bb;
        end else if (gg == hi) begin
          num = 2 * spread + (bb - rr);
        end else begin
          num = 4 * spread + (rr - gg);
        end
        if (num < 0) num += 6 * spread;
        res.hue = frac_t'((num << FracBits) / (6 * spread));
      end
      return res;
    endfunction

    function void note_pixel(chan_t r, chan_t g, chan_t b);
      expected_hsv_q.push_back(predict_hsv(r, g, b));
    endfunction

    function void check_result(frac_t hue, frac_t sat, chan_t bri);
      hsv_t want;
      if (expected_hsv_q.size() == 0) begin
        fail_count++;
        if (fail_count <= 10)
          $display("ERROR %0t: result with no pending pixel: hue=%0d sat=%0d bri=%0d",
                   $realtime, hue, sat, bri);
        return;
      end
      want = expected_hsv_q.pop_front();
      if (hue !== want.hue || sat !== want.saturation || bri !== want.brightness) begin
        fail_count++;
        if (fail_count <= 10)
          $display("ERROR %0t: hue %0d/%0d sat %0d/%0d bri %0d/%0d (expected/actual)",
                   $realtime, want.hue, hue, want.saturation, sat, want.brightness, bri);
      end
    endfunction
  endclass

  logic  clk_i       = 1'b0;
  logic  rst_ni      = 1'b0;
  logic  in_valid_i  = 1'b0;
  logic  in_stall_o;
  chan_t red_i       = '0;
  chan_t green_i     = '0;
  chan_t blue_i      = '0;
  logic  out_valid_o;
  logic  out_stall_i = 1'b0;
  frac_t hue_o;
  frac_t saturation_o;
  chan_t brightness_o;

  // Random idling on both sides; cleared for a long stretch mid-run
  logic throttle_en = 1'b1;

  hsv_scoreboard board = new();

  rgb_to_hsv_converter dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .red_i       (red_i),
    .green_i     (green_i),
    .blue_i      (blue_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .hue_o       (hue_o),
    .saturation_o(saturation_o),
    .brightness_o(brightness_o)
  );

  // 20 ns clock
  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  // Output side: check each transaction, then pick the next stall
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i)
      board.check_result(hue_o, saturation_o, brightness_o);
    out_stall_i <= throttle_en && ($urandom_range(99) < 34);
  end

  // Present one pixel and hold it until the block takes it
  task automatic send_pixel(input int r, input int g, input int b);
    while (throttle_en && $urandom_range(99) < 34) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    red_i      <= chan_t'(r);
    green_i    <= chan_t'(g);
    blue_i     <= chan_t'(b);
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    board.note_pixel(chan_t'(r), chan_t'(g), chan_t'(b));
  endtask

  initial begin
    int m, o, v;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: greys, primaries, ties, wraparound, saturation edges
    send_pixel(0, 0, 0);
    send_pixel(255, 255, 255);
    send_pixel(128, 128, 128);
    send_pixel(1, 1, 1);
    send_pixel(255, 0, 0);
    send_pixel(0, 255, 0);
    send_pixel(0, 0, 255);
    send_pixel(255, 255, 0);
    send_pixel(0, 255, 255);
    send_pixel(255, 0, 255);
    send_pixel(255, 0, 1);
    send_pixel(255, 0, 254);
    send_pixel(255, 1, 0);
    send_pixel(1, 0, 0);
    send_pixel(255, 254, 254);
    send_pixel(254, 255, 255);
    send_pixel(1, 1, 0);
    send_pixel(0, 1, 1);
    send_pixel(200, 100, 100);
    send_pixel(128, 64, 200);
    send_pixel(170, 85, 0);
    send_pixel(85, 170, 255);

    // Random pixels, weighted toward greys, ties and edge values
    for (int i = 0; i < 950; i++) begin
      throttle_en <= !(i >= 350 && i < 550);
      case ($urandom_range(9))
        4: begin
          v = $urandom_range(255);
          send_pixel(v, v, v);
        end
        5: begin
          m = $urandom_range(1, 255);
          o = $urandom_range(0, m - 1);
          case ($urandom_range(2))
            0: send_pixel(m, m, o);
            1: send_pixel(o, m, m);
            default: send_pixel(m, o, m);
          endcase
        end
        6: begin
          case ($urandom_range(2))
            0: send_pixel(0, $urandom_range(255), $urandom_range(255));
            1: send_pixel($urandom_range(255), 0, $urandom_range(255));
            default: send_pixel($urandom_range(255), $urandom_range(255), 0);
          endcase
        end
        7: send_pixel($urandom_range(3), $urandom_range(3), $urandom_range(3));
        8: send_pixel($urandom_range(250, 255), $urandom_range(250, 255),
                      $urandom_range(250, 255));
        9: begin
          v = $urandom_range(1, 254);
          send_pixel(v + $urandom_range(2) - 1, v + $urandom_range(2) - 1,
                     v + $urandom_range(2) - 1);
        end
        default: send_pixel($urandom_range(255), $urandom_range(255), $urandom_range(255));
      endcase
    end
    in_valid_i <= 1'b0;

    // Drain, then keep watching for stray results before the verdict
    while (board.expected_hsv_q.size() != 0) @(posedge clk_i);
    repeat (2 * Latency) @(posedge clk_i);

    if (board.fail_count == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #2000000;
    $display("ERROR: timeout with %0d results pending", board.expected_hsv_q.size());
    $display("*** FAILED ***");
    $finish;
  end

endmodule
